### rtl/core/scc_count_kosaraju_assert.svh
// Assertion macros shared by the strongly connected component counter.
// Needs a clock and an active-low reset passed in by the user.
`ifndef SCC_COUNT_KOSARAJU_ASSERT_SVH
`define SCC_COUNT_KOSARAJU_ASSERT_SVH

// Condition implies consequence in the same cycle.
`define SCC_ASSERT_IMPLY(lbl, clk, rst_n, cond, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// Condition implies consequence in the next cycle.
`define SCC_ASSERT_NEXT(lbl, clk, rst_n, cond, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/scc_pkg.sv
// Shared types and constants for the strongly connected component counter.
// No dependencies.
`timescale 1ns / 1ps

package scc_pkg;

    localparam int CFG_W   = 7;
    localparam int FIELD_W = 6;
    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    localparam logic CMD_ADD = 1'b0;
    localparam logic CMD_RUN = 1'b1;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_ADD   = 9'b000000010,
        ST_SCAN1 = 9'b000000100,
        ST_SCAN2 = 9'b000001000,
        ST_FETCH = 9'b000010000,
        ST_EVAL  = 9'b000100000,
        ST_POP   = 9'b001000000,
        ST_DONE  = 9'b010000000,
        ST_CLEAR = 9'b100000000
    } t_state;

endpackage

### rtl/core/scc_ram.sv
// Generic simple dual-port RAM, one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module scc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/scc_pick.sv
// Lowest unvisited neighbor below the vertex count in one matrix row.
// No dependencies.
`timescale 1ns / 1ps

module scc_pick #(
    parameter int NV = 64
) (
    input  logic [NV-1:0]              i_row,
    input  logic [NV-1:0]              i_visited,
    input  logic [$clog2(NV+1)-1:0]    i_count,
    output logic                       o_found,
    output logic [$clog2(NV)-1:0]      o_vertex
);

    localparam int NW = $clog2(NV + 1);
    localparam int VW = $clog2(NV);

    logic [NV-1:0] w_cand;

    always_comb begin
        for (int k = 0; k < NV; k++) begin
            w_cand[k] = i_row[k] & ~i_visited[k] & (NW'(k) < i_count);
        end
        o_found  = 1'b0;
        o_vertex = '0;
        for (int k = NV - 1; k >= 0; k--) begin
            if (w_cand[k]) begin
                o_found  = 1'b1;
                o_vertex = VW'(k);
            end
        end
    end

endmodule

### rtl/core/scc_count_kosaraju.sv
// Strongly connected component counter: an add-edge word reads the rows, then
// writes back both matrices. A run word walks both depth-first passes out of
// the row memories: the first pass scans the vertices in order, the second
// takes the finish entries in reverse; each descent stays in the evaluation
// state, and each return goes through a pop state back to it, unless the
// return empties the walk stack. It then posts the count, held while an
// earlier count still waits, and clears all MAX_VERTICES rows of both
// matrices, one row per cycle; the same sweep follows reset. Input is stalled
// from the accepting edge until the block is idle again.
// Depends on scc_pkg, scc_ram, scc_pick and scc_count_kosaraju_assert.svh.
`timescale 1ns / 1ps
`include "scc_count_kosaraju_assert.svh"

module scc_count_kosaraju #(
    parameter int MAX_VERTICES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_command,
    input  logic [5:0]  i_edge_source,
    input  logic [5:0]  i_edge_target,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [6:0]  o_component_count,
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_wdata
);

    localparam int NV = MAX_VERTICES;
    localparam int NW = $clog2(NV + 1);
    localparam int VW = $clog2(NV);
    localparam int CW = (NW > scc_pkg::CFG_W) ? NW : scc_pkg::CFG_W;

    scc_pkg::t_state r_state, n_state;
    logic [scc_pkg::CFG_W-1:0] r_cfg;
    logic [NV-1:0] r_visited, n_visited;
    logic [NW-1:0] r_scan, n_scan, r_depth, n_depth, r_fd, n_fd, r_count, n_count;
    logic [VW-1:0] r_top, n_top, r_src, n_src, r_dst, n_dst, r_clr, n_clr;
    logic          r_pass2, n_pass2;
    logic          r_out_valid, n_out_valid;
    logic [6:0]    r_out_count, n_out_count;

    logic [NW-1:0] w_n;
    logic [CW-1:0] w_cfg_ext;
    logic          w_edge_ok, w_in_take;

    logic          adj_we, tr_we;
    logic [VW-1:0] adj_waddr, adj_raddr, tr_waddr, tr_raddr;
    logic [NV-1:0] adj_wdata, tr_wdata, adj_rdata, tr_rdata, w_row;
    logic          stk_we, fin_we;
    logic [VW-1:0] stk_waddr, stk_raddr, stk_wdata, stk_rdata;
    logic [VW-1:0] fin_waddr, fin_raddr, fin_wdata, fin_rdata;
    logic          w_found;
    logic [VW-1:0] w_nb;

    assign w_cfg_ext = CW'(r_cfg);
    assign w_n = (w_cfg_ext > CW'(NV)) ? NW'(NV) : NW'(w_cfg_ext);
    assign w_edge_ok = (CW'(i_edge_source) < CW'(w_n)) && (CW'(i_edge_target) < CW'(w_n));
    assign o_in_stall = (r_state != scc_pkg::ST_IDLE);
    assign w_in_take = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_component_count = r_out_count;
    assign w_row = r_pass2 ? tr_rdata : adj_rdata;

    scc_ram #(.WIDTH(NV), .DEPTH(NV)) u_adj (
        .i_clk(i_clk), .i_we(adj_we), .i_waddr(adj_waddr), .i_wdata(adj_wdata),
        .i_raddr(adj_raddr), .o_rdata(adj_rdata)
    );
    scc_ram #(.WIDTH(NV), .DEPTH(NV)) u_tr (
        .i_clk(i_clk), .i_we(tr_we), .i_waddr(tr_waddr), .i_wdata(tr_wdata),
        .i_raddr(tr_raddr), .o_rdata(tr_rdata)
    );
    scc_ram #(.WIDTH(VW), .DEPTH(NV)) u_stk (
        .i_clk(i_clk), .i_we(stk_we), .i_waddr(stk_waddr), .i_wdata(stk_wdata),
        .i_raddr(stk_raddr), .o_rdata(stk_rdata)
    );
    scc_ram #(.WIDTH(VW), .DEPTH(NV)) u_fin (
        .i_clk(i_clk), .i_we(fin_we), .i_waddr(fin_waddr), .i_wdata(fin_wdata),
        .i_raddr(fin_raddr), .o_rdata(fin_rdata)
    );
    scc_pick #(.NV(NV)) u_pick (
        .i_row(w_row), .i_visited(r_visited), .i_count(w_n),
        .o_found(w_found), .o_vertex(w_nb)
    );

    always_comb begin
        n_state = r_state;
        n_visited = r_visited;
        n_scan = r_scan;
        n_depth = r_depth;
        n_fd = r_fd;
        n_count = r_count;
        n_top = r_top;
        n_src = r_src;
        n_dst = r_dst;
        n_clr = r_clr;
        n_pass2 = r_pass2;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_count = r_out_count;
        adj_we = 1'b0; adj_waddr = r_src; adj_wdata = adj_rdata; adj_raddr = r_top;
        tr_we = 1'b0; tr_waddr = r_dst; tr_wdata = tr_rdata; tr_raddr = r_top;
        stk_we = 1'b0; stk_waddr = VW'(r_depth); stk_wdata = w_nb;
        stk_raddr = VW'(r_depth - NW'(2));
        fin_we = 1'b0; fin_waddr = VW'(r_fd); fin_wdata = r_top;
        fin_raddr = VW'(r_fd - NW'(1));
        unique case (r_state)
            scc_pkg::ST_IDLE: begin
                adj_raddr = VW'(i_edge_source);
                tr_raddr = VW'(i_edge_target);
                n_src = VW'(i_edge_source);
                n_dst = VW'(i_edge_target);
                if (w_in_take) begin
                    if (i_command == scc_pkg::CMD_RUN) begin
                        n_visited = '0;
                        n_scan = '0;
                        n_fd = '0;
                        n_count = '0;
                        n_pass2 = 1'b0;
                        n_state = scc_pkg::ST_SCAN1;
                    end else if (w_edge_ok) begin
                        n_state = scc_pkg::ST_ADD;
                    end
                end
            end
            scc_pkg::ST_ADD: begin
                adj_we = 1'b1;
                adj_wdata = adj_rdata | (NV'(1) << r_dst);
                tr_we = 1'b1;
                tr_wdata = tr_rdata | (NV'(1) << r_src);
                n_state = scc_pkg::ST_IDLE;
            end
            scc_pkg::ST_SCAN1: begin
                adj_raddr = VW'(r_scan);
                if (r_scan == w_n) begin
                    n_visited = '0;
                    n_pass2 = 1'b1;
                    n_state = scc_pkg::ST_SCAN2;
                end else if (r_visited[VW'(r_scan)]) begin
                    n_scan = r_scan + NW'(1);
                end else begin
                    n_visited[VW'(r_scan)] = 1'b1;
                    n_top = VW'(r_scan);
                    stk_we = 1'b1;
                    stk_waddr = '0;
                    stk_wdata = VW'(r_scan);
                    n_depth = NW'(1);
                    n_scan = r_scan + NW'(1);
                    n_state = scc_pkg::ST_EVAL;
                end
            end
            scc_pkg::ST_SCAN2: begin
                if (r_fd == '0) begin
                    n_state = scc_pkg::ST_DONE;
                end else begin
                    n_fd = r_fd - NW'(1);
                    n_state = scc_pkg::ST_FETCH;
                end
            end
            scc_pkg::ST_FETCH: begin
                tr_raddr = fin_rdata;
                if (r_visited[fin_rdata]) begin
                    n_state = scc_pkg::ST_SCAN2;
                end else begin
                    n_visited[fin_rdata] = 1'b1;
                    n_count = r_count + NW'(1);
                    n_top = fin_rdata;
                    stk_we = 1'b1;
                    stk_waddr = '0;
                    stk_wdata = fin_rdata;
                    n_depth = NW'(1);
                    n_state = scc_pkg::ST_EVAL;
                end
            end
            scc_pkg::ST_EVAL: begin
                if (w_found) begin
                    adj_raddr = w_nb;
                    tr_raddr = w_nb;
                    n_visited[w_nb] = 1'b1;
                    stk_we = 1'b1;
                    n_top = w_nb;
                    n_depth = r_depth + NW'(1);
                end else begin
                    fin_we = !r_pass2;
                    if (!r_pass2) begin
                        n_fd = r_fd + NW'(1);
                    end
                    n_depth = r_depth - NW'(1);
                    if (r_depth == NW'(1)) begin
                        n_state = r_pass2 ? scc_pkg::ST_SCAN2 : scc_pkg::ST_SCAN1;
                    end else begin
                        n_state = scc_pkg::ST_POP;
                    end
                end
            end
            scc_pkg::ST_POP: begin
                adj_raddr = stk_rdata;
                tr_raddr = stk_rdata;
                n_top = stk_rdata;
                n_state = scc_pkg::ST_EVAL;
            end
            scc_pkg::ST_DONE: begin
                if (!n_out_valid) begin
                    n_out_valid = 1'b1;
                    n_out_count = 7'(r_count);
                    n_clr = '0;
                    n_state = scc_pkg::ST_CLEAR;
                end
            end
            scc_pkg::ST_CLEAR: begin
                adj_we = 1'b1; adj_waddr = r_clr; adj_wdata = '0;
                tr_we = 1'b1; tr_waddr = r_clr; tr_wdata = '0;
                n_clr = r_clr + VW'(1);
                if (r_clr == VW'(NV - 1)) begin
                    n_state = scc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = scc_pkg::ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= scc_pkg::ST_CLEAR;
            r_cfg <= scc_pkg::CFG_RESET;
            r_visited <= '0;
            r_scan <= '0;
            r_depth <= '0;
            r_fd <= '0;
            r_count <= '0;
            r_clr <= '0;
            r_pass2 <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            r_visited <= n_visited;
            r_scan <= n_scan;
            r_depth <= n_depth;
            r_fd <= n_fd;
            r_count <= n_count;
            r_clr <= n_clr;
            r_pass2 <= n_pass2;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top <= n_top;
        r_src <= n_src;
        r_dst <= n_dst;
        r_out_count <= n_out_count;
    end

    `SCC_ASSERT_IMPLY(a_depth_bound, i_clk, i_rst_n, r_state == scc_pkg::ST_EVAL, (r_depth != '0) && (r_depth <= w_n), "walk depth out of range")
    `SCC_ASSERT_IMPLY(a_finish_bound, i_clk, i_rst_n, r_state != scc_pkg::ST_IDLE, r_fd <= NW'(NV), "finish depth overflow")
    `SCC_ASSERT_IMPLY(a_count_bound, i_clk, i_rst_n, r_state == scc_pkg::ST_DONE, r_count <= w_n, "component count above vertex count")
    `SCC_ASSERT_NEXT(a_add_follows, i_clk, i_rst_n, w_in_take && (i_command == scc_pkg::CMD_ADD) && w_edge_ok, r_state == scc_pkg::ST_ADD, "edge write back missed")

endmodule
